// ----- src/asfm_pkg.sv -----
package asfm_pkg;

    // Character codes seen on the sensor link.
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    // Offset that makes three raw bytes into a value: 48*100 + 48*10 + 48.
    localparam logic [15:0] DIGIT_BIAS = 16'd5328;
    localparam logic [15:0] WEIGHT_HUNDREDS = 16'd100;
    localparam logic [15:0] WEIGHT_TENS     = 16'd10;

    // Sensor slot codes.
    typedef logic [1:0] t_slot;
    localparam t_slot SLOT_FIRST  = 2'd0;
    localparam t_slot SLOT_SECOND = 2'd1;
    localparam t_slot SLOT_STATUS = 2'd2;

    // Status bit positions, both in the frame value and in the sticky flags.
    localparam int FLAG_TEMP  = 0;
    localparam int FLAG_HUMID = 1;
    localparam int FLAG_RAIN  = 2;
    localparam int FLAG_BASE  = 3;
    localparam int FLAG_ANY   = 4;
    localparam int FLAG_W     = 5;

    // Configuration port.
    localparam int CFG_ADDR_W = 8;
    localparam int LIMIT_W    = 10;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_LIMIT  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SECOND_LIMIT = 8'd1;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET      = 10'd500;

    // Frame queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded frame as it travels from the front to the back.
    typedef struct packed {
        t_slot       slot;
        logic [15:0] value;
    } t_frame;

endpackage

// ----- src/asfm_front.sv -----
module asfm_front
    import asfm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  logic [7:0] i_rx_byte,
    output logic   o_push,
    output t_frame o_frame
);

    logic [7:0] r_win [4];
    logic [7:0] n_win [4];
    t_slot      r_slot;
    t_slot      n_slot;
    logic       frame_hit;
    logic       zero_case;
    logic [15:0] raw_sum;

    // After the shift the oldest byte is the current second byte.
    assign frame_hit = (r_win[1] == CHAR_LF);
    assign zero_case = (r_win[3] == CHAR_CR) && (i_rx_byte == CHAR_LF);

    // Unchecked three-digit decode, wrapped to sixteen bits.
    assign raw_sum = {8'd0, r_win[2]} * WEIGHT_HUNDREDS
                   + {8'd0, r_win[3]} * WEIGHT_TENS
                   + {8'd0, i_rx_byte}
                   - DIGIT_BIAS;

    assign o_push       = i_accept && frame_hit;
    assign o_frame.slot = r_slot;
    assign o_frame.value = zero_case ? 16'd0 : raw_sum;

    // Window shift, cleared after every frame.
    always_comb begin
        if (frame_hit) begin
            n_win[0] = 8'd0;
            n_win[1] = 8'd0;
            n_win[2] = 8'd0;
            n_win[3] = 8'd0;
        end else begin
            n_win[0] = r_win[1];
            n_win[1] = r_win[2];
            n_win[2] = r_win[3];
            n_win[3] = i_rx_byte;
        end
    end

    // Slot rotation on each frame.
    always_comb begin
        case (r_slot)
            SLOT_FIRST:  n_slot = SLOT_SECOND;
            SLOT_SECOND: n_slot = SLOT_STATUS;
            default:     n_slot = SLOT_FIRST;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= 8'd0;
            r_win[1] <= 8'd0;
            r_win[2] <= 8'd0;
            r_win[3] <= 8'd0;
            r_slot   <= SLOT_FIRST;
        end else if (i_accept) begin
            r_win <= n_win;
            if (frame_hit) begin
                r_slot <= n_slot;
            end
        end
    end

    // The slot code never reaches three.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("front slot counter out of range");

    // A frame always leaves an empty window behind.
    a_win_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_win[0] == 8'd0) && (r_win[3] == 8'd0))
        else $error("window not cleared after a frame");

endmodule

// ----- src/asfm_queue.sv -----
module asfm_queue
    import asfm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_frame o_frame
);

    t_frame              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];

    // Entry storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("frame pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("frame popped from an empty queue");

endmodule

// ----- src/asfm_back.sv -----
module asfm_back
    import asfm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_valid,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [LIMIT_W-1:0]    i_cfg_data,
    input  logic   i_q_valid,
    input  t_frame i_q_frame,
    output logic   o_q_pop,
    output logic   o_m_tvalid,
    input  logic   i_m_tready,
    output logic [23:0] o_m_tdata,
    output logic [1:0]  o_m_tuser
);

    logic [LIMIT_W-1:0] r_first_limit;
    logic [LIMIT_W-1:0] r_second_limit;
    logic [15:0]        r_first;
    logic [15:0]        r_second;
    logic [15:0]        n_first;
    logic [15:0]        n_second;
    logic [FLAG_W-1:0]  r_flags;
    logic [FLAG_W-1:0]  n_flags;
    logic               n_stop;
    logic               n_ret;
    logic               n_close;
    logic               r_out_valid;
    logic [23:0]        r_out_data;
    t_slot              r_out_slot;

    assign o_q_pop    = i_q_valid && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_slot;

    // Limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_limit  <= LIMIT_RESET;
            r_second_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_addr == REG_FIRST_LIMIT) begin
                r_first_limit <= i_cfg_data;
            end else if (i_cfg_addr == REG_SECOND_LIMIT) begin
                r_second_limit <= i_cfg_data;
            end
        end
    end

    // Store the frame in its slot and decode the status bits.
    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_flags  = r_flags;
        n_stop   = 1'b0;
        n_ret    = 1'b0;
        case (i_q_frame.slot)
            SLOT_FIRST:  n_first  = i_q_frame.value;
            SLOT_SECOND: n_second = i_q_frame.value;
            SLOT_STATUS: begin
                if (i_q_frame.value[FLAG_TEMP]) begin
                    n_flags[FLAG_TEMP] = 1'b1;
                    n_flags[FLAG_ANY]  = 1'b1;
                    n_stop             = 1'b1;
                end
                if (i_q_frame.value[FLAG_HUMID]) begin
                    n_flags[FLAG_HUMID] = 1'b1;
                    n_flags[FLAG_ANY]   = 1'b1;
                    n_stop              = 1'b1;
                end
                if (i_q_frame.value[FLAG_RAIN]) begin
                    n_flags[FLAG_RAIN] = 1'b1;
                    n_flags[FLAG_ANY]  = 1'b1;
                    n_ret              = 1'b1;
                end
                if (i_q_frame.value[FLAG_BASE]) begin
                    n_flags[FLAG_BASE] = 1'b1;
                end
            end
            default: begin
                n_flags = r_flags;
            end
        endcase
    end

    // Signed reading against the unsigned limit.
    assign n_close = ($signed(n_first)  > $signed({6'd0, r_first_limit})) ||
                     ($signed(n_second) > $signed({6'd0, r_second_limit}));

    // Sensor state, updated once per frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 16'd0;
            r_second <= 16'd0;
            r_flags  <= '0;
        end else if (o_q_pop) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_flags  <= n_flags;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_slot <= i_q_frame.slot;
            r_out_data <= {n_flags[FLAG_ANY], n_flags[FLAG_BASE], n_flags[FLAG_RAIN],
                           n_flags[FLAG_HUMID], n_flags[FLAG_TEMP],
                           n_ret, n_stop, n_close, i_q_frame.value};
        end
    end

    // The any-error flag follows the three error flags exactly.
    a_any_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags[FLAG_ANY] == (r_flags[FLAG_TEMP] || r_flags[FLAG_HUMID]
                              || r_flags[FLAG_RAIN]))
        else $error("any-error flag out of step");

    // Motor and return requests come only from status frames.
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[17] || r_out_data[18])) |-> r_out_slot == SLOT_STATUS)
        else $error("status request on a wire frame");

    // Sticky flags never clear outside reset.
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_flags & $past(r_flags)) == $past(r_flags)) || !$past(i_rst_n))
        else $error("sticky flag cleared");

endmodule

// ----- src/ascii_sensor_frame_monitor.sv -----
// Path: once a frame's last byte is accepted, the frame is pushed into the queue; the back pops it
// and registers its result in the output register, which holds it until the result is taken.
// Throughput: one received byte per cycle; one result per completed frame, at most every fourth byte.
// The input stalls only while the two-entry frame queue is full behind a stalled output.
// Bytes that complete no frame only shift the window and produce nothing.
// Reset (i_rst_n low, synchronous) clears window, slot, readings and flags; limits go to 500.
module ascii_sensor_frame_monitor
    import asfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received bytes: tdata[7:0] rx_byte.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // Results: tdata[15:0] frame_value, [16] wire_close, [17] stop_motor,
    // [18] return_to_base, [19] temp_error_seen, [20] humidity_error_seen,
    // [21] rain_seen, [22] at_base, [23] any_error_seen.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,
    // Results: tuser[1:0] slot.
    output logic [1:0]  o_m_tuser,
    // Register writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [LIMIT_W-1:0]    i_cfg_data
);

    logic   q_full;
    logic   push;
    t_frame push_frame;
    logic   pop;
    logic   q_valid;
    t_frame q_frame;
    logic   in_accept;

    assign o_s_tready  = !q_full;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_s_tvalid && o_s_tready;

    asfm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_s_tdata),
        .o_push    (push),
        .o_frame   (push_frame)
    );

    asfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_frame (q_frame)
    );

    asfm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_frame   (q_frame),
        .o_q_pop     (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

// ----- dv/tb_ascii_sensor_frame_monitor.sv -----
module tb_ascii_sensor_frame_monitor
    import asfm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // ASCII zero, used to build digit bytes.
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    // Settling wait once no result is awaited any more, with some margin.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any transaction before the run is abandoned.
    localparam int IDLE_LIMIT = 2000;
    // Random bytes per configuration phase.
    localparam int PHASE_BYTES = 75;

    // One decoded frame as it leaves the block.
    typedef struct packed {
        t_slot              slot;
        logic [15:0]        value;
        logic               close;
        logic               stop;
        logic               ret;
        logic [FLAG_W-1:0]  flags;
    } t_frame_result;

    // Mirrors the frame decoder and keeps the frames it expects to see.
    class t_frame_checker;
        logic [7:0]          window [4];
        t_slot               slot_now;
        logic signed [15:0]  first_reading;
        logic signed [15:0]  second_reading;
        logic [FLAG_W-1:0]   sticky;
        logic [LIMIT_W-1:0]  first_limit;
        logic [LIMIT_W-1:0]  second_limit;
        t_frame_result       awaited_frames [$];
        string               flag_name [FLAG_W];
        int                  errors;

        function new();
            flag_name[FLAG_TEMP]  = "temp_error_seen";
            flag_name[FLAG_HUMID] = "humidity_error_seen";
            flag_name[FLAG_RAIN]  = "rain_seen";
            flag_name[FLAG_BASE]  = "at_base";
            flag_name[FLAG_ANY]   = "any_error_seen";
            foreach (window[i]) window[i] = '0;
            slot_now       = SLOT_FIRST;
            first_reading  = '0;
            second_reading = '0;
            sticky         = '0;
            first_limit    = LIMIT_RESET;
            second_limit   = LIMIT_RESET;
            errors         = 0;
        endfunction

        // Register write as the block applies it; unknown indexes are dropped.
        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [LIMIT_W-1:0] data);
            if (addr == REG_FIRST_LIMIT) begin
                first_limit = data;
            end else if (addr == REG_SECOND_LIMIT) begin
                second_limit = data;
            end
        endfunction

        // Shift one accepted byte in and predict the frame it completes, if any.
        function void take_byte(logic [7:0] b);
            int            raw;
            logic [15:0]   value;
            t_frame_result predicted;
            window[0] = window[1];
            window[1] = window[2];
            window[2] = window[3];
            window[3] = b;
            if (window[0] != CHAR_LF) return;

            // A CR LF in the last two bytes of a frame reads as zero; otherwise digits are unchecked.
            if (window[2] == CHAR_CR && window[3] == CHAR_LF) begin
                raw = 0;
            end else begin
                raw = int'(window[1]) * int'(WEIGHT_HUNDREDS)
                    + int'(window[2]) * int'(WEIGHT_TENS)
                    + int'(window[3]) - int'(DIGIT_BIAS);
            end
            value = raw[15:0];
            foreach (window[i]) window[i] = '0;

            predicted       = '0;
            predicted.slot  = slot_now;
            predicted.value = value;
            case (slot_now)
                SLOT_FIRST: begin
                    first_reading = value;
                    slot_now      = SLOT_SECOND;
                end
                SLOT_SECOND: begin
                    second_reading = value;
                    slot_now       = SLOT_STATUS;
                end
                SLOT_STATUS: begin
                    // Status bits come from the low bits of the 16-bit form.
                    if (value[FLAG_TEMP]) begin
                        sticky[FLAG_TEMP] = 1'b1;
                        sticky[FLAG_ANY]  = 1'b1;
                        predicted.stop    = 1'b1;
                    end
                    if (value[FLAG_HUMID]) begin
                        sticky[FLAG_HUMID] = 1'b1;
                        sticky[FLAG_ANY]   = 1'b1;
                        predicted.stop     = 1'b1;
                    end
                    if (value[FLAG_RAIN]) begin
                        sticky[FLAG_RAIN] = 1'b1;
                        sticky[FLAG_ANY]  = 1'b1;
                        predicted.ret     = 1'b1;
                    end
                    if (value[FLAG_BASE]) begin
                        sticky[FLAG_BASE] = 1'b1;
                    end
                    slot_now = SLOT_FIRST;
                end
                default: begin
                    slot_now = SLOT_FIRST;
                end
            endcase
            predicted.close = (int'(first_reading) > int'(first_limit)) ||
                              (int'(second_reading) > int'(second_limit));
            predicted.flags = sticky;
            awaited_frames.push_back(predicted);
        endfunction

        // Compare one accepted result with the oldest awaited frame.
        function void check_frame(t_frame_result got);
            t_frame_result want;
            if (awaited_frames.size() == 0) begin
                $error("unexpected result: slot %0d frame_value %0d",
                       got.slot, $signed(got.value));
                errors++;
                return;
            end
            want = awaited_frames.pop_front();
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                errors++;
            end
            if (got.value !== want.value) begin
                $error("frame_value: expected %0d, actual %0d",
                       $signed(want.value), $signed(got.value));
                errors++;
            end
            if (got.close !== want.close) begin
                $error("wire_close: expected %0d, actual %0d", want.close, got.close);
                errors++;
            end
            if (got.stop !== want.stop) begin
                $error("stop_motor: expected %0d, actual %0d", want.stop, got.stop);
                errors++;
            end
            if (got.ret !== want.ret) begin
                $error("return_to_base: expected %0d, actual %0d", want.ret, got.ret);
                errors++;
            end
            for (int i = 0; i < FLAG_W; i++) begin
                if (got.flags[i] !== want.flags[i]) begin
                    $error("%s: expected %0d, actual %0d",
                           flag_name[i], want.flags[i], got.flags[i]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return awaited_frames.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [23:0]           o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [LIMIT_W-1:0]    i_cfg_data  = '0;

    t_frame_checker scoreboard = new();

    int burst_left  = 0;
    int bytes_sent  = 0;
    int stall_left  = 0;
    int run_left    = 0;
    int idle_cycles = 0;

    ascii_sensor_frame_monitor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Result side: check every accepted transaction, and stall in runs of random length.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            scoreboard.check_frame({o_m_tuser, o_m_tdata[15:0], o_m_tdata[16],
                                    o_m_tdata[17], o_m_tdata[18], o_m_tdata[23:19]});
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
            i_m_tready <= 1'b1;
        end else begin
            run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            i_m_tready <= 1'b1;
        end
    end

    // Abandon the run when no transaction of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one byte, opening a gap first when the current burst is used up.
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        scoreboard.take_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] b1, input logic [7:0] b2,
                              input logic [7:0] b3);
        send_byte(CHAR_LF);
        send_byte(b1);
        send_byte(b2);
        send_byte(b3);
    endtask

    // A well-formed frame carrying a three-digit decimal number.
    task automatic send_number(input int n);
        send_frame(CHAR_ZERO + 8'(n / 100), CHAR_ZERO + 8'((n / 10) % 10),
                   CHAR_ZERO + 8'(n % 10));
    endtask

    // One random unit of traffic: mostly good frames, the rest odd frames and noise.
    task automatic send_random_unit();
        int pick;
        int n;
        int offset;
        logic [LIMIT_W-1:0] limit;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            n = $urandom_range(0, 999);
            limit = (scoreboard.slot_now == SLOT_SECOND) ? scoreboard.second_limit
                                                         : scoreboard.first_limit;
            // Often land right on the threshold of the wire about to be stored.
            if ($urandom_range(0, 3) == 0) begin
                offset = $urandom_range(0, 2);
                n = int'(limit) + offset - 1;
                if (n < 0) n = 0;
                if (n > 999) n = 999;
            end
            send_number(n);
        end else if (pick < 70) begin
            send_number($urandom_range(0, 15));
        end else if (pick < 80) begin
            send_frame(8'($urandom_range(0, 255)), CHAR_CR, CHAR_LF);
        end else if (pick < 90) begin
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        end else begin
            // Noise, sometimes with a stray line feed that frames misaligned bytes.
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_byte(CHAR_LF);
                end else begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // Stop sending and wait until the block has nothing left in flight.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (scoreboard.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [LIMIT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        scoreboard.write_reg(addr, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // New limits on an idle block, then a stretch of random traffic.
    task automatic run_phase(input logic [LIMIT_W-1:0] first, input logic [LIMIT_W-1:0] second);
        int start;
        wait_idle();
        cfg_write(REG_FIRST_LIMIT, first);
        cfg_write(REG_SECOND_LIMIT, second);
        if ($urandom_range(0, 1) == 0) begin
            cfg_write(CFG_ADDR_W'($urandom_range(2, 255)), LIMIT_W'($urandom_range(0, 1023)));
        end
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) send_random_unit();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset limits.
        send_frame(8'h00, 8'h00, 8'h00);                  // most negative value
        send_frame(8'hFF, 8'hFF, 8'hFF);                  // largest value, wire close
        send_number(8);                                   // at base alone leaves any clear
        send_frame(CHAR_ZERO + 8'd7, CHAR_CR, CHAR_LF);   // CR LF frame reads as zero
        send_number(999);
        send_frame(8'h00, 8'h00, CHAR_ZERO + 8'd4);       // negative status, rain bit
        send_byte(8'h55);
        send_byte(8'hAA);

        // Limits at both extremes and in between; an unknown index is sometimes tried.
        run_phase(10'd0, 10'd0);
        run_phase(10'd999, 10'd999);
        run_phase(10'd0, 10'd999);
        run_phase(10'd999, 10'd0);
        run_phase(LIMIT_W'($urandom_range(0, 999)), LIMIT_W'($urandom_range(0, 999)));
        run_phase(LIMIT_W'($urandom_range(0, 999)), LIMIT_W'($urandom_range(0, 999)));
        run_phase(LIMIT_RESET, LIMIT_W'($urandom_range(0, 999)));

        wait_idle();
        if (scoreboard.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
